>>> design/mrtm_pkg.sv
`timescale 1ns / 1ps

package mrtm_pkg;

  localparam int unsigned TIME_W      = 64;
  localparam int unsigned THR_W       = 40;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IN_TDATA_W  = 3 * TIME_W;

  // Minimum step between consecutive local time points, in ticks (1 us).
  localparam logic [TIME_W-1:0] MIN_STEP  = TIME_W'(1000);
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(100000000);

  localparam int unsigned RES_FIFO_DEPTH = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SCHEDULE = 2'd0,
    FUNC_ADVANCE  = 2'd1,
    FUNC_INIT     = 2'd2,
    FUNC_RESET    = 2'd3
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TIME = 2'd0,
    KIND_DISC = 2'd1,
    KIND_ACK  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TIME_W-1:0] local_time;
    logic              last_of_run;
  } res_t;

  // Push request from the compute stage into the result queue.
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

endpackage

>>> design/mrtm_res_fifo.sv
`timescale 1ns / 1ps

module mrtm_res_fifo #(
  parameter int unsigned Depth = mrtm_pkg::RES_FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mrtm_pkg::push_t push_i,
  input  mrtm_pkg::res_t  wr_first_i,
  input  mrtm_pkg::res_t  wr_second_i,
  output logic          room_o,
  output logic          rd_valid_o,
  output mrtm_pkg::res_t  rd_data_o,
  input  logic          rd_ready_i
);
  import mrtm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  // Room for the worst case of two results from one item.
  assign room_o     = (cnt_q <= CntW'(Depth - 2));
  assign wptr_nxt   = inc(wptr_q);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i.two) begin
      wptr_d = inc(wptr_nxt);
      cnt_d  = cnt_d + CntW'(2);
    end else if (push_i.one) begin
      wptr_d = wptr_nxt;
      cnt_d  = cnt_d + CntW'(1);
    end
    if (pop) begin
      rptr_d = inc(rptr_q);
      cnt_d  = cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.one || push_i.two) begin
      mem_q[wptr_q] <= wr_first_i;
    end
    if (push_i.two) begin
      mem_q[wptr_nxt] <= wr_second_i;
    end
  end

endmodule

>>> design/monotonic_remote_time_mapper.sv
`timescale 1ns / 1ps
// Channel   | Signals                           | Fields (low bit first)
// ----------+-----------------------------------+-------------------------------------
// s_axis    | tvalid tready tdata[191:0] tuser  | tdata: time_value, local_now,
//           |                                   |   step_delta; tuser: func
// m_axis    | tvalid tready tdata[63:0] tuser   | tdata: local_time; tuser: kind;
//           | tlast                             |   tlast: last_of_run
// cfg       | cfg_we_i cfg_wdata_i[39:0]        | jump_threshold
//
// An accepted item sits in the input register; once the queue has room for two, all its math
// runs against the offset/last-time state and its one or two results enter a small result queue,
// from which m_axis reads them in order.
// One item per cycle sustained while the queue has room; a schedule that emits a discontinuity
// notice puts an extra result on the output side, so the m_axis drain rate sets the pace.
// Reset clears the state, the input register and the queue at once; the threshold
// returns to its reset value. tready drops only while an item waits in the input
// register and the queue lacks room for two.

module monotonic_remote_time_mapper #(
  parameter int unsigned ResFifoDepth = mrtm_pkg::RES_FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: time_value [63:0], local_now [127:64], step_delta [191:128]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mrtm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [mrtm_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  // tdata: local_time [63:0]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mrtm_pkg::TIME_W-1:0]     m_axis_tdata_o,
  // tuser: kind [1:0]
  output logic [mrtm_pkg::KIND_W-1:0]     m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_we_i,
  input  logic [mrtm_pkg::THR_W-1:0]      cfg_wdata_i
);
  import mrtm_pkg::*;

  // Input register
  logic              in_vld_q;
  logic [TIME_W-1:0] tv_q, now_q, delta_q;
  func_e             func_q;

  // Mapper state
  logic [TIME_W-1:0] offset_q, offset_d;
  logic [TIME_W-1:0] last_q, last_d;
  logic              last_vld_q, last_vld_d;
  logic              first_q, first_d;
  logic [THR_W-1:0]  thr_q;

  logic   room, advance, s_accept;
  push_t  push;
  res_t   res_first, res_second, rd_data;

  logic [TIME_W-1:0] thr64, base_last, mapped0, mapped, last_a, next_t, sched_t;
  logic              reanchor, disc;

  assign advance         = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || room;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Payload holds while the item waits for queue room.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tv_q    <= s_axis_tdata_i[TIME_W-1:0];
      now_q   <= s_axis_tdata_i[2*TIME_W-1:TIME_W];
      delta_q <= s_axis_tdata_i[3*TIME_W-1:2*TIME_W];
      func_q  <= func_e'(s_axis_tuser_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Schedule datapath; all comparisons are signed on wrapped 64-bit sums.
  assign thr64     = {{(TIME_W-THR_W){1'b0}}, thr_q};
  assign base_last = last_vld_q ? last_q : now_q;
  assign mapped0   = tv_q + offset_q;
  assign reanchor  = first_q
                  || ($signed(mapped0) < $signed(now_q))
                  || ($signed(base_last + thr64) < $signed(mapped0));
  // Large jump: a re-anchor other than the first, with mapped time outside now +/- threshold.
  assign disc      = reanchor && !first_q
                  && (($signed(mapped0) < $signed(now_q - thr64))
                   || ($signed(now_q + thr64) < $signed(mapped0)));
  assign last_a    = disc ? base_last + MIN_STEP : base_last;
  // A re-anchored offset maps the remote time exactly onto now.
  assign mapped    = reanchor ? now_q : mapped0;
  assign next_t    = last_a + MIN_STEP;
  assign sched_t   = ($signed(next_t) < $signed(mapped)) ? mapped : next_t;

  always_comb begin
    offset_d   = offset_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    first_d    = first_q;
    push       = '0;
    res_first  = '{kind: KIND_TIME, local_time: '0, last_of_run: 1'b1};
    res_second = '{kind: KIND_TIME, local_time: sched_t, last_of_run: 1'b1};
    if (advance) begin
      unique case (func_q)
        FUNC_SCHEDULE: begin
          if (reanchor) begin
            offset_d = now_q - tv_q;
          end
          last_d     = sched_t;
          last_vld_d = 1'b1;
          first_d    = 1'b0;
          if (disc) begin
            // Discontinuity notice first, then the scheduled time.
            push.two  = 1'b1;
            res_first = '{kind: KIND_DISC, local_time: last_a, last_of_run: 1'b0};
          end else begin
            push.one  = 1'b1;
            res_first = res_second;
          end
        end
        FUNC_ADVANCE: begin
          last_d     = base_last + delta_q;
          last_vld_d = 1'b1;
          push.one   = 1'b1;
          res_first  = '{kind: KIND_TIME, local_time: base_last + delta_q, last_of_run: 1'b1};
        end
        FUNC_INIT: begin
          offset_d   = '0;
          last_d     = tv_q;
          last_vld_d = 1'b1;
          first_d    = 1'b1;
          push.one   = 1'b1;
          res_first  = '{kind: KIND_ACK, local_time: tv_q, last_of_run: 1'b1};
        end
        FUNC_RESET: begin
          offset_d   = '0;
          last_d     = '0;
          last_vld_d = 1'b0;
          first_d    = 1'b1;
          push.one   = 1'b1;
          res_first  = '{kind: KIND_ACK, local_time: '0, last_of_run: 1'b1};
        end
        default: begin
          push = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      first_q    <= 1'b1;
    end else begin
      offset_q   <= offset_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
      first_q    <= first_d;
    end
  end

  // Result queue parts the compute stage from the output stall.
  mrtm_res_fifo #(
    .Depth (ResFifoDepth)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr_first_i  (res_first),
    .wr_second_i (res_second),
    .room_o      (room),
    .rd_valid_o  (m_axis_tvalid_o),
    .rd_data_o   (rd_data),
    .rd_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = rd_data.local_time;
  assign m_axis_tuser_o = rd_data.kind;
  assign m_axis_tlast_o = rd_data.last_of_run;

endmodule

>>> design/mrtm_checker.sv
`timescale 1ns / 1ps

module mrtm_props (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [mrtm_pkg::TIME_W-1:0]     m_axis_tdata_o,
  input logic [mrtm_pkg::KIND_W-1:0]     m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import mrtm_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // A discontinuity notice never closes a run; its scheduled time follows at once.
  a_disc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_DISC) |-> !m_axis_tlast_o)
    else $error("discontinuity marked last");

  a_disc_then_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && (m_axis_tuser_o == KIND_DISC) |=>
      m_axis_tvalid_o && (m_axis_tuser_o == KIND_TIME) && m_axis_tlast_o)
    else $error("discontinuity not followed by scheduled time");

  // Acknowledges always close their run.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_ACK) |-> m_axis_tlast_o)
    else $error("acknowledge not marked last");

endmodule

bind monotonic_remote_time_mapper mrtm_props u_mrtm_props (.*);

>>> test/mrtm_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the threshold port, tracks the mapper state and compares each
// output transfer against the oldest predicted result.
module mrtm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: time_value [63:0], local_now [127:64], step_delta [191:128]
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [mrtm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [mrtm_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  // tdata: local_time [63:0]
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [mrtm_pkg::TIME_W-1:0]     m_axis_tdata_i,
  // tuser: kind [1:0]
  input  logic [mrtm_pkg::KIND_W-1:0]     m_axis_tuser_i,
  input  logic                            m_axis_tlast_i,
  input  logic                            cfg_we_i,
  input  logic [mrtm_pkg::THR_W-1:0]      cfg_wdata_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import mrtm_pkg::*;

  localparam int unsigned MAX_PRINTED = 40;

  logic [TIME_W-1:0] threshold_q;
  logic [TIME_W-1:0] offset_q;
  logic [TIME_W-1:0] last_time_q;
  logic              last_valid_q;
  logic              first_sched_q;
  res_t              expected_times[$];
  res_t              oldest;
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    end
  endtask

  function automatic void push_time(kind_e k, logic [TIME_W-1:0] t, logic lst);
    expected_times.push_back('{kind: k, local_time: t, last_of_run: lst});
  endfunction

  function automatic void clear_timeline();
    offset_q      = '0;
    last_time_q   = '0;
    last_valid_q  = 1'b0;
    first_sched_q = 1'b1;
  endfunction

  // Advance the mapper state by one accepted input and queue what it produces.
  function automatic void map_transfer(func_e f, logic [TIME_W-1:0] tv,
                                       logic [TIME_W-1:0] now, logic [TIME_W-1:0] delta);
    logic [TIME_W-1:0] mapped;
    logic [TIME_W-1:0] nxt;
    mapped = tv + offset_q;
    case (f)
      FUNC_SCHEDULE: begin
        if (!last_valid_q) begin
          last_time_q  = now;
          last_valid_q = 1'b1;
        end
        if (first_sched_q || $signed(mapped) < $signed(now) ||
            $signed(last_time_q + threshold_q) < $signed(mapped)) begin
          if (!first_sched_q && ($signed(mapped) < $signed(now - threshold_q) ||
                                 $signed(now + threshold_q) < $signed(mapped))) begin
            last_time_q = last_time_q + MIN_STEP;
            push_time(KIND_DISC, last_time_q, 1'b0);
          end
          offset_q = now - tv;
          mapped   = tv + offset_q;
        end
        nxt           = last_time_q + MIN_STEP;
        last_time_q   = ($signed(nxt) < $signed(mapped)) ? mapped : nxt;
        first_sched_q = 1'b0;
        push_time(KIND_TIME, last_time_q, 1'b1);
      end
      FUNC_ADVANCE: begin
        if (!last_valid_q) begin
          last_time_q  = now;
          last_valid_q = 1'b1;
        end
        last_time_q = last_time_q + delta;
        push_time(KIND_TIME, last_time_q, 1'b1);
      end
      FUNC_INIT: begin
        clear_timeline();
        last_time_q  = tv;
        last_valid_q = 1'b1;
        push_time(KIND_ACK, last_time_q, 1'b1);
      end
      default: begin
        clear_timeline();
        push_time(KIND_ACK, '0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = {{(TIME_W - THR_W){1'b0}}, THR_RESET};
      clear_timeline();
      expected_times.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        threshold_q = {{(TIME_W - THR_W){1'b0}}, cfg_wdata_i};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_times.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_i, '0);
        end else begin
          oldest = expected_times.pop_front();
          if (m_axis_tuser_i !== oldest.kind) begin
            report_mismatch("kind", 64'(m_axis_tuser_i), 64'(oldest.kind));
          end
          if (m_axis_tdata_i !== oldest.local_time) begin
            report_mismatch("local_time", m_axis_tdata_i, oldest.local_time);
          end
          if (m_axis_tlast_i !== oldest.last_of_run) begin
            report_mismatch("last_of_run", 64'(m_axis_tlast_i), 64'(oldest.last_of_run));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        map_transfer(func_e'(s_axis_tuser_i), s_axis_tdata_i[63:0],
                     s_axis_tdata_i[127:64], s_axis_tdata_i[191:128]);
      end
      pending_o <= expected_times.size();
    end
  end

endmodule

>>> test/tb_monotonic_remote_time_mapper.sv
`timescale 1ns / 1ps

module tb_monotonic_remote_time_mapper;
  import mrtm_pkg::*;

  localparam logic [63:0] TMAX         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TMIN         = 64'h8000_0000_0000_0000;
  localparam logic [39:0] THR_MAX      = 40'hFF_FFFF_FFFF;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // tdata: time_value [63:0], local_now [127:64], step_delta [191:128]
  logic [IN_TDATA_W-1:0] s_axis_tdata_i  = '0;
  // tuser: func [1:0]
  logic [FUNC_W-1:0]     s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // tdata: local_time [63:0]
  logic [TIME_W-1:0]     m_axis_tdata_o;
  // tuser: kind [1:0]
  logic [KIND_W-1:0]     m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_we_i        = 1'b0;
  logic [THR_W-1:0]      cfg_wdata_i     = '0;

  int unsigned           fail_count;
  int unsigned           pending;

  // Long receiver hold-off request, raised once by the stimulus.
  logic                  hold_req        = 1'b0;

  // Stimulus-side view of the clocks, used only to shape well-formed schedules.
  logic [63:0]           remote_clk;
  logic [63:0]           local_clk;
  logic [63:0]           thr_cur;
  int unsigned           burst_left      = 0;

  monotonic_remote_time_mapper u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  mrtm_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one item and hold it until the transfer happens. Leave tvalid high so that
  // a following item can go out back to back.
  task automatic send_item(input func_e f, input logic [63:0] tv, input logic [63:0] now,
                           input logic [63:0] delta);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= f;
    s_axis_tdata_i  <= {delta, now, tv};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
  endtask

  // Sender pacing: bursts of random length, then a gap that may be empty.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop tvalid and wait until every predicted result has come out.
  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write the threshold only with the block idle.
  task automatic write_threshold(input logic [39:0] value);
    wait_drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    thr_cur = {24'd0, value};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed schedules along two advancing clocks, with jumps of both signs,
  // advances, initialize and reset, plus fully random noise.
  task automatic random_item();
    int unsigned pick;
    logic [63:0] tv;
    pick = $urandom_range(0, 99);
    local_clk = local_clk + $urandom_range(0, 4000);
    if (pick < 55) begin
      remote_clk = remote_clk + $urandom_range(0, 4000);
      tv = remote_clk;
      case ($urandom_range(0, 9))
        0: begin
          tv = remote_clk + (thr_cur << 1) + $urandom_range(1, 1 << 20);
          remote_clk = tv;
        end
        1: begin
          tv = remote_clk - (thr_cur << 1) - $urandom_range(1, 1 << 20);
          remote_clk = tv;
        end
        2: tv = remote_clk + thr_cur + $urandom_range(0, 3000);
        3: tv = remote_clk - $urandom_range(0, 20000);
        default: ;
      endcase
      send_item(FUNC_SCHEDULE, tv, local_clk, rand64());
    end else if (pick < 65) begin
      send_item(FUNC_ADVANCE, rand64(), local_clk, 64'($urandom_range(0, 5000)));
    end else if (pick < 70) begin
      send_item(FUNC_ADVANCE, rand64(), local_clk, rand64());
    end else if (pick < 75) begin
      if ($urandom_range(0, 1) == 0) begin
        tv = local_clk;
      end else begin
        tv = rand64();
        local_clk = tv;
      end
      send_item(FUNC_INIT, tv, rand64(), rand64());
    end else if (pick < 78) begin
      send_item(FUNC_RESET, rand64(), rand64(), rand64());
    end else begin
      send_item(func_e'($urandom_range(0, 3)), rand64(), rand64(), rand64());
    end
    pace();
  endtask

  // Receiver: stall on a pattern of shifting modes, and hold off once for a long
  // stretch so that the result queue fills and the input stalls.
  initial begin : result_sink
    int unsigned stall_run;
    int unsigned mode;
    int unsigned mode_left;
    bit          hold_done;
    stall_run = 0;
    mode      = 0;
    mode_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        if (stall_run > 0) begin
          stall_run--;
          m_axis_tready_i <= 1'b0;
        end else begin
          case (mode)
            0: m_axis_tready_i <= 1'b1;
            1: m_axis_tready_i <= $urandom_range(0, 1);
            2: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
            default: begin
              stall_run = $urandom_range(0, 7);
              m_axis_tready_i <= (stall_run == 0);
            end
          endcase
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("monotonic_remote_time_mapper verification failed");
    $finish;
  end

  initial begin : stimulus
    thr_cur    = {24'd0, THR_RESET};
    remote_clk = 64'd5000;
    local_clk  = 64'd10000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default threshold.
    // First schedule always anchors, then an in-range one.
    send_item(FUNC_SCHEDULE, 64'd5000, 64'd10000, 64'd0);
    send_item(FUNC_SCHEDULE, 64'd5500, 64'd10200, 64'd0);
    // Mapped time in the past: re-anchor without a notice.
    send_item(FUNC_SCHEDULE, 64'd4000, 64'd20000, 64'd0);
    // Jumps beyond the threshold both ways: notice first.
    send_item(FUNC_SCHEDULE, 64'd2_000_000_000, 64'd20500, 64'd0);
    pace();
    send_item(FUNC_SCHEDULE, -64'd2_000_000_000, 64'd21000, 64'd0);
    // Advance by zero and by the signed extremes.
    send_item(FUNC_ADVANCE, 64'd0, 64'd0, 64'd0);
    send_item(FUNC_ADVANCE, 64'd0, 64'd0, TMAX);
    send_item(FUNC_ADVANCE, 64'd0, 64'd0, TMIN);
    pace();
    // Initialize at the top of the range, then schedule across the wrap.
    send_item(FUNC_INIT, TMAX, 64'd0, 64'd0);
    send_item(FUNC_SCHEDULE, 64'd0, TMIN, 64'd0);
    send_item(FUNC_SCHEDULE, 64'd100, TMAX, 64'd0);
    // Reset, then advance with no valid last time: load from the clock sample.
    send_item(FUNC_RESET, TMAX, TMIN, TMAX);
    send_item(FUNC_ADVANCE, 64'd0, 64'd777, 64'd5);
    pace();
    send_item(FUNC_RESET, 64'd0, 64'd0, 64'd0);
    send_item(FUNC_SCHEDULE, TMIN, TMAX, 64'd0);
    send_item(FUNC_SCHEDULE, TMAX, TMIN, TMAX);
    // Initialize at the bottom, step back through the wrap.
    send_item(FUNC_INIT, TMIN, 64'd0, 64'd0);
    send_item(FUNC_ADVANCE, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    // Last time near the top so that last time plus threshold wraps negative.
    send_item(FUNC_INIT, 64'h7FFF_FFFF_FFF0_0000, 64'd0, 64'd0);
    send_item(FUNC_SCHEDULE, 64'd0, 64'h7FFF_FFFF_FFF0_0000, 64'd0);
    send_item(FUNC_SCHEDULE, 64'd2000, 64'h7FFF_FFFF_FFF0_0100, 64'd0);
    send_item(FUNC_RESET, 64'd0, 64'd0, 64'd0);

    // Random part across threshold settings: default, zero, maximum, small, random,
    // and back to the reset value.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: write_threshold(40'd0);
        2: write_threshold(THR_MAX);
        3: write_threshold(40'd5000);
        4: write_threshold(40'(rand64()));
        5: write_threshold(THR_RESET);
        default: ;
      endcase
      // Ask for the long hold-off while items keep flowing in the zero-threshold phase.
      if (p == 1) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("monotonic_remote_time_mapper verification clean");
    end else begin
      $display("monotonic_remote_time_mapper verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mrtm_pkg.sv
design/mrtm_res_fifo.sv
design/monotonic_remote_time_mapper.sv
design/mrtm_checker.sv
test/mrtm_checker.sv
test/tb_monotonic_remote_time_mapper.sv
